[src/adx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adx_pkg
// Shared types and constants for the ADX trend strength block.
// ----------------------------------------------------------------------------
package adx_pkg;

  localparam int PRICE_FRACTION_BITS_DEF = 16;
  localparam int MAX_PERIOD_DEF = 64;
  localparam int EXTRA_BITS = 8;
  localparam int ACC_W = 40;
  localparam int PER_W = 7;
  localparam int THR_W = 23;
  localparam int ADX_W = 23;
  localparam int SIG_W = 2;
  localparam int CNT_W = 8;
  localparam logic [ADX_W-1:0] ADX_HUNDRED = 23'd6553600;
  localparam logic [PER_W-1:0] PERIOD_RESET = 7'd14;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 23'd1638400;

  localparam logic [0:0] REG_PERIOD = 1'b0;
  localparam logic [0:0] REG_THRESHOLD = 1'b1;

  localparam logic [SIG_W-1:0] SIG_BUY = 2'd0;
  localparam logic [SIG_W-1:0] SIG_SELL = 2'd1;
  localparam logic [SIG_W-1:0] SIG_HOLD = 2'd2;

  // one bar as held in the queue between front and back
  typedef struct packed {
    logic [31:0] bar_high;
    logic [31:0] bar_low;
    logic        in_window;
  } bar_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOVE,
    ST_DIV_P,
    ST_DIV_M,
    ST_SUM,
    ST_DIV_DX,
    ST_DIV_S,
    ST_EMIT
  } state_t;

endpackage

[src/adx_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adx_queue
// Two-entry bar queue between the front and the back.
// ----------------------------------------------------------------------------
module adx_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  adx_pkg::bar_t  push_data,
  output logic           full,
  input  logic           pop,
  output adx_pkg::bar_t  pop_data,
  output logic           empty
);

  adx_pkg::bar_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

[src/adx_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adx_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module adx_divider #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 41
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   trial;

  assign trial = {rem, q[NUM_W-1]} - {1'b0, den};
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= numer;
      rem <= '0;
      den <= denom;
    end else if (busy) begin
      if (!trial[DEN_W]) begin
        rem <= trial[DEN_W-1:0];
        q   <= {q[NUM_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DEN_W-2:0], q[NUM_W-1]};
        q   <= {q[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

[src/adx_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adx_back
// Smoothing engine: directional movement, DX and ADX over a shared divider.
// ----------------------------------------------------------------------------
module adx_back #(
  parameter int MAX_PERIOD = adx_pkg::MAX_PERIOD_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       bar_valid,
  input  adx_pkg::bar_t              bar,
  output logic                       bar_pop,
  input  logic [adx_pkg::PER_W-1:0]  period_length,
  input  logic [adx_pkg::THR_W-1:0]  trend_threshold,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [adx_pkg::ADX_W-1:0]  adx_value,
  output logic [adx_pkg::SIG_W-1:0]  trade_signal
);

  localparam int AW = adx_pkg::ACC_W;
  localparam int NW = 64;
  localparam int DW = AW + 1;
  localparam int PW = adx_pkg::PER_W;
  localparam logic [AW-1:0] ACC_MAX = '1;
  localparam int MAXP = (MAX_PERIOD > 127) ? 127 : MAX_PERIOD;

  adx_pkg::state_t state, state_next;

  logic [31:0]      last_high, last_low;
  logic             have_prev;
  logic [7:0]       bar_count;
  logic [AW-1:0]    s_plus, s_minus, s_dx;
  logic [AW-1:0]    dp, dm;
  logic [PW-1:0]    n;
  logic             seed_mv, seed_dx;
  logic [7:0]       cnt_new;
  logic             emit_go;

  logic             div_start, div_done;
  logic [NW-1:0]    div_num, div_quot;
  logic [DW-1:0]    div_den;
  logic [AW:0]      sum;
  logic [AW-1:0]    diff;
  logic [AW-1:0]    adx_full;
  logic [adx_pkg::ADX_W-1:0] adx_sat;

  // effective period, clamped
  always_comb begin
    if (period_length < PW'(2)) n = PW'(2);
    else if (period_length > PW'(MAXP)) n = PW'(MAXP);
    else n = period_length;
  end

  assign cnt_new = (bar_count == 8'd255) ? bar_count : bar_count + 8'd1;
  assign seed_mv = {1'b0, cnt_new} < {2'b0, n};
  assign seed_dx = {1'b0, cnt_new} < ({1'b0, n, 1'b0} - 9'd1);

  assign dp = (bar.bar_high > last_high)
            ? AW'(bar.bar_high - last_high) << adx_pkg::EXTRA_BITS : '0;
  assign dm = (last_low > bar.bar_low)
            ? AW'(last_low - bar.bar_low) << adx_pkg::EXTRA_BITS : '0;

  assign sum  = {1'b0, s_plus} + {1'b0, s_minus};
  assign diff = (s_plus > s_minus) ? s_plus - s_minus : s_minus - s_plus;

  assign emit_go = !res_valid || res_ready;

  function automatic logic [NW-1:0] wilder_num(logic [AW-1:0] old, logic [AW-1:0] val,
                                               logic [PW-1:0] nn, logic seed);
    logic [NW-1:0] prod;
    begin
      prod = NW'(old) * NW'(nn - PW'(1));
      wilder_num = seed ? NW'(val) : prod + NW'(val);
    end
  endfunction

  function automatic logic [AW-1:0] wilder_res(logic [AW-1:0] old, logic [NW-1:0] q,
                                               logic seed);
    logic [NW-1:0] t;
    begin
      t = seed ? NW'(old) + q : q;
      wilder_res = (t > NW'(ACC_MAX)) ? ACC_MAX : t[AW-1:0];
    end
  endfunction

  adx_divider #(.NUM_W(NW), .DEN_W(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_num),
    .denom (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign adx_full = s_dx >> adx_pkg::EXTRA_BITS;
  assign adx_sat  = (adx_full > AW'(adx_pkg::ADX_HUNDRED))
                  ? adx_pkg::ADX_HUNDRED : adx_full[adx_pkg::ADX_W-1:0];

  always_comb begin
    state_next = state;
    bar_pop    = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = DW'(n);
    unique case (state)
      adx_pkg::ST_IDLE: begin
        if (bar_valid) begin
          state_next = have_prev ? adx_pkg::ST_MOVE : adx_pkg::ST_EMIT;
        end
      end
      adx_pkg::ST_MOVE: begin
        div_start  = 1'b1;
        div_num    = wilder_num(s_plus, dp, n, seed_mv);
        state_next = adx_pkg::ST_DIV_P;
      end
      adx_pkg::ST_DIV_P: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_num    = wilder_num(s_minus, dm, n, seed_mv);
          state_next = adx_pkg::ST_DIV_M;
        end
      end
      adx_pkg::ST_DIV_M: begin
        if (div_done) state_next = adx_pkg::ST_SUM;
      end
      adx_pkg::ST_SUM: begin
        if (sum == '0) begin
          state_next = adx_pkg::ST_DIV_S;
          div_start  = 1'b1;
          div_num    = wilder_num(s_dx, '0, n, seed_dx);
        end else begin
          div_start  = 1'b1;
          div_num    = NW'(diff) * NW'(adx_pkg::ADX_HUNDRED);
          div_den    = sum;
          state_next = adx_pkg::ST_DIV_DX;
        end
      end
      adx_pkg::ST_DIV_DX: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_num    = wilder_num(s_dx, AW'(div_quot) << adx_pkg::EXTRA_BITS, n, seed_dx);
          state_next = adx_pkg::ST_DIV_S;
        end
      end
      adx_pkg::ST_DIV_S: begin
        if (div_done) state_next = adx_pkg::ST_EMIT;
      end
      adx_pkg::ST_EMIT: begin
        if (emit_go) begin
          bar_pop    = 1'b1;
          state_next = adx_pkg::ST_IDLE;
        end
      end
      default: state_next = adx_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= adx_pkg::ST_IDLE;
      have_prev <= 1'b0;
      bar_count <= '0;
      last_high <= '0;
      last_low  <= '0;
      s_plus    <= '0;
      s_minus   <= '0;
      s_dx      <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == adx_pkg::ST_EMIT) && emit_go) res_valid <= bar.in_window;
      else if (res_ready) res_valid <= 1'b0;
      unique case (state)
        adx_pkg::ST_DIV_P: if (div_done) s_plus <= wilder_res(s_plus, div_quot, seed_mv);
        adx_pkg::ST_DIV_M: if (div_done) s_minus <= wilder_res(s_minus, div_quot, seed_mv);
        adx_pkg::ST_DIV_S: if (div_done) s_dx <= wilder_res(s_dx, div_quot, seed_dx);
        adx_pkg::ST_EMIT: begin
          if (emit_go) begin
            if (have_prev) bar_count <= cnt_new;
            have_prev <= 1'b1;
            last_high <= bar.bar_high;
            last_low  <= bar.bar_low;
            if (bar.in_window) begin
              adx_value <= adx_sat;
              if (adx_sat > trend_threshold) trade_signal <= adx_pkg::SIG_BUY;
              else if (adx_sat < trend_threshold) trade_signal <= adx_pkg::SIG_SELL;
              else trade_signal <= adx_pkg::SIG_HOLD;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_pop_once: assert property (@(posedge clk) disable iff (rst)
    bar_pop |=> !bar_pop)
    else $error("bar popped twice");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    bar_pop |-> bar_valid)
    else $error("pop from empty queue");
  a_adx_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> adx_value <= adx_pkg::ADX_HUNDRED)
    else $error("adx out of range");
`endif

endmodule

[src/adx_trend_strength_signal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adx_trend_strength_signal
// Wilder average directional index with buy / sell / hold signal.
//
// Bars enter on the s_axis channel and are held in a two-entry queue; the
// back end takes one bar at a time and smooths plus and minus movement, DX
// and ADX through one shared restoring divider. An in-window bar gives one
// beat on m_axis; a bar outside the window gives none. The first bar after
// reset has no movement and goes from idle straight to emit, with no divider
// pass. Every later bar takes four divider passes, or three when both
// smoothed movements are zero and DX needs no division. The back end takes
// no new bar from the queue until it has emitted the last one.
// Configuration writes (index 0 period, 1 threshold) are taken at any time
// on the cfg channel and must be made only while the block is idle.
// Reset clears the history, the accumulators and the queue, and loads the
// default period 14 and threshold 25.0. When m_axis stalls the result is
// held; the back end works through the next bar and waits with its result,
// and the queue keeps taking bars until full.
// ----------------------------------------------------------------------------
module adx_trend_strength_signal #(
  parameter int MAX_PERIOD = adx_pkg::MAX_PERIOD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // bar_high, bar_low, bar_close, in_window
  input  logic        m_axis_tready,
  output logic        m_axis_tvalid,
  output logic [31:0] m_axis_tdata,   // adx_value, trade_signal
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [adx_pkg::PER_W-1:0] period_length;
  logic [adx_pkg::THR_W-1:0] trend_threshold;
  adx_pkg::bar_t             in_bar, q_bar;
  logic                      q_full, q_empty, q_pop;
  logic [adx_pkg::ADX_W-1:0] adx_value;
  logic [adx_pkg::SIG_W-1:0] trade_signal;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_length   <= adx_pkg::PERIOD_RESET;
      trend_threshold <= adx_pkg::THRESHOLD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        adx_pkg::REG_PERIOD:    period_length <= cfg_data[adx_pkg::PER_W-1:0];
        adx_pkg::REG_THRESHOLD: trend_threshold <= cfg_data[adx_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_bar.bar_high  = s_axis_tdata[31:0];
  assign in_bar.bar_low   = s_axis_tdata[63:32];
  assign in_bar.in_window = s_axis_tdata[96];
  assign s_axis_tready    = !q_full;

  adx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid && !q_full),
    .push_data (in_bar),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_bar),
    .empty     (q_empty)
  );

  adx_back #(.MAX_PERIOD(MAX_PERIOD)) u_back (
    .clk             (clk),
    .rst             (rst),
    .bar_valid       (!q_empty),
    .bar             (q_bar),
    .bar_pop         (q_pop),
    .period_length   (period_length),
    .trend_threshold (trend_threshold),
    .res_valid       (m_axis_tvalid),
    .res_ready       (m_axis_tready),
    .adx_value       (adx_value),
    .trade_signal    (trade_signal)
  );

  assign m_axis_tdata = {7'd0, trade_signal, adx_value};

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ADX trend strength block.
//
// Price bars are queued by the stimulus process and offered on s_axis by a
// clocked driver; each accepted bar is run through a local ADX predictor
// and in-window bars leave an expected beat. A clocked monitor compares
// every m_axis beat with the oldest expected beat. Both sides idle at
// random, the receiver holds off once for a long stretch, and the period
// and threshold are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT = 2000000;

  typedef struct {
    logic [adx_pkg::ADX_W-1:0] adx;
    logic [adx_pkg::SIG_W-1:0] sig;
  } adx_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic m_axis_tready = 1'b0;
  logic m_axis_tvalid;
  logic [31:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = adx_pkg::REG_PERIOD;
  logic [31:0] cfg_data = '0;

  adx_trend_strength_signal uut (.*);

  always #4 clk = ~clk;

  // bench copy of the block state
  logic [adx_pkg::PER_W-1:0] cur_period = adx_pkg::PERIOD_RESET;
  logic [adx_pkg::THR_W-1:0] cur_thresh = adx_pkg::THRESHOLD_RESET;
  logic [31:0] prev_high = '0, prev_low = '0;
  logic have_prev = 1'b0;
  int unsigned bars_seen = 0;
  logic [63:0] acc_plus = '0, acc_minus = '0, acc_dx = '0;

  logic [103:0] pending_bars[$];
  adx_beat_t expected_beats[$];
  int unsigned bars_queued = 0, bars_taken = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int unsigned hold_left = 0;
  logic [31:0] walk_base = 32'h0064_0000;

  function automatic logic [63:0] wilder_step(logic [63:0] old, logic [63:0] val,
                                              logic [63:0] n, bit seeding);
    logic [63:0] r;
    if (seeding) r = old + val / n;
    else r = (old * (n - 1) + val) / n;
    if (r > 64'hFF_FFFF_FFFF) r = 64'hFF_FFFF_FFFF;
    return r;
  endfunction

  task automatic predict_bar(logic [103:0] d);
    logic [31:0] hi, lo;
    logic [63:0] n, dp, dm, sum, diff, dx, adx;
    adx_beat_t b;
    hi = d[31:0];
    lo = d[63:32];
    if (have_prev) begin
      n = cur_period < 2 ? 2 : (cur_period > adx_pkg::MAX_PERIOD_DEF
                                ? adx_pkg::MAX_PERIOD_DEF : cur_period);
      dp = hi > prev_high ? hi - prev_high : 0;
      dm = prev_low > lo ? prev_low - lo : 0;
      if (bars_seen < 255) bars_seen++;
      acc_plus = wilder_step(acc_plus, dp << adx_pkg::EXTRA_BITS, n, bars_seen < n);
      acc_minus = wilder_step(acc_minus, dm << adx_pkg::EXTRA_BITS, n, bars_seen < n);
      sum = acc_plus + acc_minus;
      if (sum == 0) dx = 0;
      else begin
        diff = acc_plus > acc_minus ? acc_plus - acc_minus : acc_minus - acc_plus;
        dx = diff * 64'd6553600 / sum;
      end
      acc_dx = wilder_step(acc_dx, dx << adx_pkg::EXTRA_BITS, n, bars_seen < 2 * n - 1);
    end
    prev_high = hi;
    prev_low = lo;
    have_prev = 1'b1;
    if (d[96]) begin
      adx = acc_dx >> adx_pkg::EXTRA_BITS;
      if (adx > adx_pkg::ADX_HUNDRED) adx = adx_pkg::ADX_HUNDRED;
      b.adx = adx[adx_pkg::ADX_W-1:0];
      if (b.adx > cur_thresh) b.sig = adx_pkg::SIG_BUY;
      else if (b.adx < cur_thresh) b.sig = adx_pkg::SIG_SELL;
      else b.sig = adx_pkg::SIG_HOLD;
      expected_beats.insert(expected_beats.size(), b);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_bar(s_axis_tdata);
        bars_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_bars.size() > 0 && (quiet || $urandom_range(99) >= 26)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_bars.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done && hold_left == 0) begin
      hold_left <= 3000;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    adx_beat_t e;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, m_axis_tdata);
          errors++;
        end else begin
          e = expected_beats.pop_front();
          if (m_axis_tdata[22:0] !== e.adx) begin
            $display("%0t: adx expected %0d actual %0d", $time, e.adx, m_axis_tdata[22:0]);
            errors++;
          end
          if (m_axis_tdata[24:23] !== e.sig) begin
            $display("%0t: signal expected %0d actual %0d", $time, e.sig,
                     m_axis_tdata[24:23]);
            errors++;
          end
        end
      end
      m_axis_tready <= (hold_left == 0) && !(hold_req && !hold_done) &&
                       (quiet || $urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_bar(logic [31:0] hi, logic [31:0] lo, logic win);
    pending_bars.insert(pending_bars.size(), {7'd0, win, $urandom(), lo, hi});
    bars_queued++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (bars_taken != bars_queued || expected_beats.size() != 0);
    repeat (1000) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == adx_pkg::REG_PERIOD) cur_period = val[adx_pkg::PER_W-1:0];
    else cur_thresh = val[adx_pkg::THR_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic queue_random_bar();
    logic [31:0] hi, lo, spread;
    logic win;
    win = $urandom_range(99) < 80;
    if ($urandom_range(99) < 75) begin
      walk_base = walk_base + $urandom_range(32'h0004_0000) - 32'h0002_0000;
      if (walk_base < 32'h0010_0000 || walk_base > 32'hF000_0000) walk_base = 32'h0064_0000;
      spread = $urandom_range(32'h0003_0000);
      hi = walk_base + spread;
      lo = walk_base - spread;
    end else begin
      hi = $urandom();
      lo = $urandom();
    end
    queue_bar(hi, lo, win);
  endtask

  logic [adx_pkg::PER_W-1:0] phase_period[8] =
    '{7'd2, 7'd64, 7'd0, 7'd127, 7'd1, 7'd20, 7'd5, 7'd14};
  logic [31:0] phase_thresh[8];

  initial begin
    phase_thresh = '{32'd0, 32'd6553600, 32'd8388607, 32'd1638400,
                     $urandom_range(6553600), $urandom_range(6553600),
                     $urandom_range(6553600), 32'd1638400};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: first bar, zero movement, price extremes
    queue_bar(32'h0064_0000, 32'h005A_0000, 1'b1);
    queue_bar(32'h0064_0000, 32'h005A_0000, 1'b1);
    queue_bar(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    queue_bar(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    queue_bar(32'h0000_0000, 32'h0000_0000, 1'b1);
    queue_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    wait_idle();

    // short period, steady uptrend drives seeded adx past 100, hold at 100
    write_reg(adx_pkg::REG_PERIOD, 32'd3);
    write_reg(adx_pkg::REG_THRESHOLD, 32'd6553600);
    for (int i = 1; i <= 10; i++) queue_bar(i * 32'h0010_0000, i * 32'h000F_0000, 1'b1);
    wait_idle();
    write_reg(adx_pkg::REG_THRESHOLD, 32'd0);
    queue_bar(32'h0000_0000, 32'h0000_0000, 1'b1);
    queue_bar(32'h0000_0000, 32'h0000_0000, 1'b1);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      write_reg(adx_pkg::REG_PERIOD, {25'd0, phase_period[p]});
      write_reg(adx_pkg::REG_THRESHOLD, phase_thresh[p]);
      quiet = (p == 2);
      if (p == 4) hold_req <= 1'b1;
      for (int i = 0; i < 80; i++) queue_random_bar();
      wait_idle();
    end
    quiet = 1'b0;

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[adx_trend_strength_signal.f]
src/adx_pkg.sv
src/adx_queue.sv
src/adx_divider.sv
src/adx_back.sv
src/adx_trend_strength_signal.sv
tb/tb_top.sv
